// ----- sv/pabc_pkg.sv -----
`timescale 1ns / 1ps

package pabc_pkg;

  localparam int unsigned LevelW   = 6;
  localparam int unsigned AvgW     = 10;
  localparam int unsigned CountW   = 7;
  localparam int unsigned OffsetW  = 10;
  localparam int unsigned DelayW   = 12;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;
  localparam logic [LevelW-1:0] MaxLevel = 6'd32;

  typedef enum logic [1:0] {
    ACT_SLEEP = 2'd0,
    ACT_OFF   = 2'd1,
    ACT_BLINK = 2'd2
  } action_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TOO_FAR      = 3'd0,
    CFG_LIGHT_LIMIT  = 3'd1,
    CFG_DIST_LIMIT   = 3'd2,
    CFG_DELAY_OFFSET = 3'd3,
    CFG_LIGHT_EN     = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [LevelW-1:0]  too_far_level;
    logic [CountW-1:0]  light_quiet_limit;
    logic [CountW-1:0]  distance_quiet_limit;
    logic [OffsetW-1:0] delay_offset;
    logic               light_enable;
  } cfg_t;

  // one classified request waiting for the delay math
  typedef struct packed {
    action_t           action;
    logic              led_pin;
    logic [LevelW-1:0] gap;      // 32 - distance, 0 above range
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SQUARE,
    BK_CUBE,
    BK_OUT
  } back_state_t;

  // sample + floor(15*avg/16), kept to 10 bits
  function automatic logic [AvgW-1:0] avg_update(input logic [AvgW-1:0] avg,
                                                 input logic [LevelW-1:0] sample);
    logic [AvgW+3:0] prod;
    logic [AvgW-1:0] res;
    prod = {4'd0, avg} * 14'd15;
    res  = {4'd0, sample} + prod[AvgW+3:4];
    return res;
  endfunction

  // sample more than one away from avg/16
  function automatic logic is_change(input logic [AvgW-1:0] avg,
                                     input logic [LevelW-1:0] sample);
    logic [LevelW:0] center;
    logic [LevelW:0] s;
    center = {1'b0, avg[AvgW-1:4]};
    s      = {1'b0, sample};
    return ((s + 7'd1) < center) || (s > (center + 7'd1));
  endfunction

endpackage

// ----- sv/pabc_if.sv -----
`timescale 1ns / 1ps

interface pabc_in_if;
  import pabc_pkg::*;
  logic              valid;
  logic              ready;
  logic [LevelW-1:0] light_level;
  logic [LevelW-1:0] distance_level;
  modport source (output valid, output light_level, output distance_level, input ready);
  modport sink   (input valid, input light_level, input distance_level, output ready);
endinterface

interface pabc_out_if;
  import pabc_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic              led_pin;
  logic [DelayW-1:0] delay_ms;
  modport source (output valid, output action, output led_pin, output delay_ms, input ready);
  modport sink   (input valid, input action, input led_pin, input delay_ms, output ready);
endinterface

// ----- sv/pabc_front.sv -----
`timescale 1ns / 1ps

module pabc_front import pabc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  pabc_in_if.sink   in_ch,
  input  cfg_t      cfg,
  input  logic      q_full,
  output logic      push,
  output job_t      push_job
);

  logic [AvgW-1:0]   light_avg_r, light_avg_nxt;
  logic [AvgW-1:0]   dist_avg_r, dist_avg_nxt;
  logic [CountW-1:0] light_cnt_r, light_cnt_nxt;
  logic [CountW-1:0] dist_cnt_r, dist_cnt_nxt;
  logic              waiting_r, waiting_nxt;
  logic              led_r, led_nxt;

  logic [LevelW-1:0] light, dist_lvl;
  logic              near;
  logic              light_sleep;
  logic [CountW:0]   tick;
  action_t           action;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;
  assign light       = in_ch.light_level;
  assign dist_lvl    = in_ch.distance_level;
  assign near        = dist_lvl <= cfg.too_far_level;

  always_comb begin
    light_avg_nxt = light_avg_r;
    dist_avg_nxt  = dist_avg_r;
    light_cnt_nxt = light_cnt_r;
    dist_cnt_nxt  = dist_cnt_r;
    waiting_nxt   = waiting_r;
    led_nxt       = led_r;
    light_sleep   = 1'b0;
    tick          = '0;
    action        = ACT_OFF;
    if (waiting_r) begin
      if (!near) begin
        led_nxt = 1'b1;
      end else begin
        waiting_nxt  = 1'b0;
        dist_cnt_nxt = '0;
        led_nxt      = !led_r;
        action       = ACT_BLINK;
      end
    end else begin
      if (cfg.light_enable) begin
        light_avg_nxt = avg_update(light_avg_r, light);
        if (is_change(light_avg_nxt, light)) begin
          light_cnt_nxt = '0;
          dist_cnt_nxt  = '0;
        end
        tick = {1'b0, light_cnt_nxt} + 8'd1;
        if (tick >= {1'b0, cfg.light_quiet_limit}) begin
          light_cnt_nxt = cfg.light_quiet_limit;
          light_sleep   = 1'b1;
        end else begin
          light_cnt_nxt = tick[CountW-1:0];
        end
      end
      if (light_sleep) begin
        action = ACT_SLEEP;
      end else if (near) begin
        led_nxt = 1'b1;
      end else begin
        dist_avg_nxt = avg_update(dist_avg_r, dist_lvl);
        if (is_change(dist_avg_nxt, dist_lvl)) begin
          dist_cnt_nxt = '0;
        end
        tick = {1'b0, dist_cnt_nxt} + 8'd1;
        if (tick >= {1'b0, cfg.distance_quiet_limit}) begin
          dist_cnt_nxt = cfg.distance_quiet_limit;
          led_nxt      = 1'b1;
          waiting_nxt  = 1'b1;
        end else begin
          dist_cnt_nxt = tick[CountW-1:0];
          led_nxt      = !led_r;
          action       = ACT_BLINK;
        end
      end
    end
  end

  always_comb begin
    push_job.action  = action;
    push_job.led_pin = led_nxt;
    push_job.gap     = (dist_lvl > MaxLevel) ? '0 : (MaxLevel - dist_lvl);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_avg_r <= '0;
      dist_avg_r  <= '0;
      light_cnt_r <= '0;
      dist_cnt_r  <= '0;
      waiting_r   <= 1'b0;
      led_r       <= 1'b0;
    end else if (push) begin
      light_avg_r <= light_avg_nxt;
      dist_avg_r  <= dist_avg_nxt;
      light_cnt_r <= light_cnt_nxt;
      dist_cnt_r  <= dist_cnt_nxt;
      waiting_r   <= waiting_nxt;
      led_r       <= led_nxt;
    end
  end

endmodule

// ----- sv/pabc_queue.sv -----
`timescale 1ns / 1ps

module pabc_queue import pabc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t pop_job,
  output logic full,
  output logic empty
);

  job_t       slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full    = count_r == 2'd2;
  assign empty   = count_r == 2'd0;
  assign pop_job = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- sv/pabc_back.sv -----
`timescale 1ns / 1ps

module pabc_back import pabc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               empty,
  input  job_t               pop_job,
  output logic               pop,
  input  logic [OffsetW-1:0] delay_offset,
  pabc_out_if.source         out_ch
);

  back_state_t       state_r, state_nxt;
  job_t              job_r;
  logic [10:0]       sq_r;
  logic [DelayW-1:0] delay_r;
  logic [16:0]       cube;
  logic [DelayW-1:0] delay_sum;

  // gap^3 peaks at 32768, so bits [15:4] hold the /16 result
  assign cube      = {6'd0, sq_r} * {11'd0, job_r.gap};
  assign delay_sum = cube[15:4] + {2'd0, delay_offset};

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!empty) begin
          pop       = 1'b1;
          state_nxt = BK_SQUARE;
        end
      end
      BK_SQUARE: state_nxt = BK_CUBE;
      BK_CUBE:   state_nxt = BK_OUT;
      BK_OUT: begin
        if (out_ch.ready) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= pop_job;
    end
    if (state_r == BK_SQUARE) begin
      sq_r <= {5'd0, job_r.gap} * {5'd0, job_r.gap};
    end
    if (state_r == BK_CUBE) begin
      delay_r <= (job_r.action == ACT_BLINK) ? delay_sum : '0;
    end
  end

  assign out_ch.valid    = state_r == BK_OUT;
  assign out_ch.action   = job_r.action;
  assign out_ch.led_pin  = job_r.led_pin;
  assign out_ch.delay_ms = delay_r;

endmodule

// ----- sv/parking_aid_blink_controller.sv -----
`timescale 1ns / 1ps
// Parking aid blink controller.
// in_ch carries one sensor loop request (light and distance ladder levels);
// out_ch returns one result per request: action, LED pin level and blink
// delay in ms. Both use valid/ready; a request moves when both are high.
// The front stage updates averages, quiet counters, wait mode and the LED
// in the accept cycle and drops a classified job into a two-entry queue.
// The back stage pops a job and squares then cubes the distance gap
// through small multipliers, adding the delay offset for blink jobs
// (other actions give a zero delay); it pops, squares, cubes and
// presents each job and takes the next only once the result is taken.
// A stalled out_ch holds the result; the front keeps taking requests until
// the queue fills, then drops in_ch.ready.
// cfg_we/cfg_index/cfg_data write registers; the user must do so only
// while the block is idle, which the block itself does not enforce.
// Synchronous reset clears control state, LED on, registers to defaults.

module parking_aid_blink_controller import pabc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  pabc_in_if.sink             in_ch,
  pabc_out_if.source          out_ch,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t cfg_r;
  logic push, pop, q_full, q_empty;
  job_t push_job, pop_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.too_far_level        <= 6'd6;
      cfg_r.light_quiet_limit    <= 7'd100;
      cfg_r.distance_quiet_limit <= 7'd30;
      cfg_r.delay_offset         <= 10'd50;
      cfg_r.light_enable         <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TOO_FAR:      cfg_r.too_far_level        <= cfg_data[LevelW-1:0];
        CFG_LIGHT_LIMIT:  cfg_r.light_quiet_limit    <= cfg_data[CountW-1:0];
        CFG_DIST_LIMIT:   cfg_r.distance_quiet_limit <= cfg_data[CountW-1:0];
        CFG_DELAY_OFFSET: cfg_r.delay_offset         <= cfg_data[OffsetW-1:0];
        CFG_LIGHT_EN:     cfg_r.light_enable         <= cfg_data[0];
        default:          cfg_r <= cfg_r;
      endcase
    end
  end

  pabc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  pabc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  pabc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (q_empty),
    .pop_job      (pop_job),
    .pop          (pop),
    .delay_offset (cfg_r.delay_offset),
    .out_ch       (out_ch)
  );

endmodule

// ----- tb/tb_parking_aid_blink_controller.sv -----
`timescale 1ns / 1ps

module tb_parking_aid_blink_controller;
  import pabc_pkg::*;

  typedef struct packed {
    logic [LevelW-1:0] light;
    logic [LevelW-1:0] dist_lvl;
  } sensor_pass_t;

  typedef struct packed {
    action_t           action;
    logic              led_pin;
    logic [DelayW-1:0] delay_ms;
  } blink_result_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  cfg_idx_t            cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  pabc_in_if  in_ch();
  pabc_out_if out_ch();

  parking_aid_blink_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow copy of the block's registers and state
  cfg_t              regs;
  logic [AvgW-1:0]   light_avg;
  logic [AvgW-1:0]   dist_avg;
  logic [CountW-1:0] light_quiet;
  logic [CountW-1:0] dist_quiet;
  logic              waiting;
  logic              led_off;

  sensor_pass_t  pass_q[$];
  blink_result_t due_results[$];

  int          n_queued;
  int          n_accepted;
  int          errors;
  int          send_gap;
  int          recv_gap;
  int          hold_cnt;
  bit          calm;
  bit          hold_req;
  bit          hold_done;
  bit          in_took;
  logic [5:0]  cur_l;
  logic [5:0]  cur_d;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [AvgW-1:0] next_avg(input logic [AvgW-1:0] avg,
                                                input logic [LevelW-1:0] s);
    logic [AvgW+3:0] p;
    p = {4'd0, avg} * 14'd15;
    return {4'd0, s} + p[AvgW+3:4];
  endfunction

  function automatic logic level_moved(input logic [AvgW-1:0] avg,
                                       input logic [LevelW-1:0] s);
    int c;
    int v;
    c = int'(avg[AvgW-1:4]);
    v = int'(s);
    return (v < c - 1) || (v > c + 1);
  endfunction

  // {reached, new count}; count is clamped to the limit once reached
  function automatic logic [CountW:0] quiet_step(input logic [CountW-1:0] cnt,
                                                 input logic [CountW-1:0] lim);
    logic [CountW:0] n;
    n = {1'b0, cnt} + 1'b1;
    if (n >= {1'b0, lim}) return {1'b1, lim};
    return {1'b0, n[CountW-1:0]};
  endfunction

  function automatic logic [DelayW-1:0] blink_ms(input logic [LevelW-1:0] d);
    int r;
    int v;
    r = (d > MaxLevel) ? 0 : int'(MaxLevel) - int'(d);
    v = r * r * r / 16 + int'(regs.delay_offset);
    return v[DelayW-1:0];
  endfunction

  function automatic blink_result_t run_pass(input logic [LevelW-1:0] light,
                                             input logic [LevelW-1:0] dist_lvl);
    blink_result_t   r;
    logic [CountW:0] q;
    logic            light_sleep;
    r.delay_ms  = '0;
    r.action    = ACT_OFF;
    light_sleep = 1'b0;
    if (waiting) begin
      if (dist_lvl > regs.too_far_level) begin
        led_off = 1'b1;
      end else begin
        waiting    = 1'b0;
        dist_quiet = '0;
        led_off    = ~led_off;
        r.delay_ms = blink_ms(dist_lvl);
        r.action   = ACT_BLINK;
      end
    end else begin
      if (regs.light_enable) begin
        light_avg = next_avg(light_avg, light);
        // a light change also restarts the distance quiet count
        if (level_moved(light_avg, light)) begin
          light_quiet = '0;
          dist_quiet  = '0;
        end
        q           = quiet_step(light_quiet, regs.light_quiet_limit);
        light_quiet = q[CountW-1:0];
        light_sleep = q[CountW];
      end
      if (light_sleep) begin
        r.action = ACT_SLEEP;
      end else if (dist_lvl <= regs.too_far_level) begin
        led_off = 1'b1;
      end else begin
        dist_avg = next_avg(dist_avg, dist_lvl);
        if (level_moved(dist_avg, dist_lvl)) dist_quiet = '0;
        q          = quiet_step(dist_quiet, regs.distance_quiet_limit);
        dist_quiet = q[CountW-1:0];
        if (q[CountW]) begin
          led_off = 1'b1;
          waiting = 1'b1;
        end else begin
          led_off    = ~led_off;
          r.delay_ms = blink_ms(dist_lvl);
          r.action   = ACT_BLINK;
        end
      end
    end
    r.led_pin = led_off;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [5:0] nudge(input logic [5:0] v);
    if (v == 0) return 6'd1;
    if (v >= MaxLevel) return MaxLevel - 6'd1;
    return $urandom_range(0, 1) ? v + 6'd1 : v - 6'd1;
  endfunction

  function automatic cfg_t mk_cfg(input int tf, input int ll, input int dl,
                                  input int off, input int en);
    cfg_t c;
    c.too_far_level        = tf[LevelW-1:0];
    c.light_quiet_limit    = ll[CountW-1:0];
    c.distance_quiet_limit = dl[CountW-1:0];
    c.delay_offset         = off[OffsetW-1:0];
    c.light_enable         = en[0];
    return c;
  endfunction

  // monitor: checks results first, then predicts any request taken this edge
  always @(posedge clk) begin : watch
    blink_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_results.size() == 0) begin
        $error("result with no pending request: action %0d led_pin %0d delay_ms %0d",
               out_ch.action, out_ch.led_pin, out_ch.delay_ms);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (out_ch.action !== want.action) begin
          $error("action: expected %0d, got %0d", want.action, out_ch.action);
          errors++;
        end
        if (out_ch.led_pin !== want.led_pin) begin
          $error("led_pin: expected %0d, got %0d", want.led_pin, out_ch.led_pin);
          errors++;
        end
        if (out_ch.delay_ms !== want.delay_ms) begin
          $error("delay_ms: expected %0d, got %0d", want.delay_ms, out_ch.delay_ms);
          errors++;
        end
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      due_results.push_back(run_pass(in_ch.light_level, in_ch.distance_level));
      n_accepted++;
    end
    in_took <= rst_n && in_ch.valid && in_ch.ready;
  end

  always @(negedge clk) begin : drive
    sensor_pass_t p;
    if (!in_ch.valid || in_took) begin
      if (send_gap > 0) begin
        in_ch.valid <= 1'b0;
        send_gap--;
      end else if (pass_q.size() > 0) begin
        p = pass_q.pop_front();
        in_ch.light_level    <= p.light;
        in_ch.distance_level <= p.dist_lvl;
        in_ch.valid          <= 1'b1;
        send_gap = pick_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : sink
    if (hold_req && !hold_done) begin
      // long hold-off so the block backs up into its input
      out_ch.ready <= 1'b0;
      hold_cnt++;
      if (hold_cnt >= 80) hold_done = 1'b1;
    end else if (recv_gap > 0) begin
      out_ch.ready <= 1'b0;
      recv_gap--;
    end else begin
      out_ch.ready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) recv_gap = pick_gap();
    end
  end

  task automatic push_pass(input logic [5:0] l, input logic [5:0] d);
    sensor_pass_t p;
    p.light    = l;
    p.dist_lvl = d;
    pass_q.push_back(p);
    n_queued++;
  endtask

  // returns at a falling edge once every request has come back
  task automatic settle();
    @(negedge clk);
    while (n_accepted != n_queued || due_results.size() != 0) @(negedge clk);
  endtask

  task automatic set_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    case (idx)
      CFG_TOO_FAR:      regs.too_far_level        = val[LevelW-1:0];
      CFG_LIGHT_LIMIT:  regs.light_quiet_limit    = val[CountW-1:0];
      CFG_DIST_LIMIT:   regs.distance_quiet_limit = val[CountW-1:0];
      CFG_DELAY_OFFSET: regs.delay_offset         = val[OffsetW-1:0];
      CFG_LIGHT_EN:     regs.light_enable         = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_cfg(input cfg_t c);
    set_reg(CFG_TOO_FAR, CfgDataW'(c.too_far_level));
    set_reg(CFG_LIGHT_LIMIT, CfgDataW'(c.light_quiet_limit));
    set_reg(CFG_DIST_LIMIT, CfgDataW'(c.distance_quiet_limit));
    set_reg(CFG_DELAY_OFFSET, CfgDataW'(c.delay_offset));
    set_reg(CFG_LIGHT_EN, CfgDataW'(c.light_enable));
    cfg_we <= 1'b0;
  endtask

  // mostly steady runs so averages settle and quiet counters climb
  task automatic fill_random(input int count);
    int         added;
    int         kind;
    int         len;
    logic [5:0] l;
    logic [5:0] d;
    logic [5:0] far_lo;
    logic [5:0] near_hi;
    added = 0;
    while (added < count) begin
      far_lo  = (regs.too_far_level >= MaxLevel) ? 6'd0 : regs.too_far_level + 6'd1;
      near_hi = (regs.too_far_level > MaxLevel) ? MaxLevel : regs.too_far_level;
      kind    = $urandom_range(0, 9);
      if (kind <= 5) begin
        if ($urandom_range(0, 2) == 0) cur_l = 6'($urandom_range(0, 32));
        if ($urandom_range(0, 2) == 0) cur_d = 6'($urandom_range(far_lo, 32));
        len = $urandom_range(3, 30);
        repeat (len) begin
          l = cur_l;
          d = cur_d;
          if ($urandom_range(0, 7) == 0) l = nudge(l);
          if ($urandom_range(0, 7) == 0) d = nudge(d);
          push_pass(l, d);
          added++;
        end
      end else if (kind <= 7) begin
        // far run, then close in: exercises wait mode exit
        len = $urandom_range(2, 8);
        repeat (len) push_pass(cur_l, 6'($urandom_range(far_lo, 32)));
        added += len;
        len = $urandom_range(1, 3);
        repeat (len) push_pass(cur_l, 6'($urandom_range(0, near_hi)));
        added += len;
      end else if (kind == 8) begin
        len = $urandom_range(1, 4);
        repeat (len) push_pass(6'($urandom_range(0, 32)), 6'($urandom_range(0, 32)));
        added += len;
      end else begin
        len = $urandom_range(1, 3);
        repeat (len) begin
          l = $urandom_range(0, 1) ? MaxLevel : 6'd0;
          case ($urandom_range(0, 3))
            0:       d = 6'd0;
            1:       d = MaxLevel;
            2:       d = regs.too_far_level;
            default: d = far_lo;
          endcase
          push_pass(l, d);
        end
        added += len;
      end
    end
  endtask

  task automatic run_phase(input cfg_t c, input int count, input bit quiet,
                           input bit squeeze);
    apply_cfg(c);
    @(posedge clk);
    calm = quiet;
    if (squeeze) hold_req = 1'b1;
    fill_random(count);
    settle();
  endtask

  initial begin : main
    in_ch.valid          = 1'b0;
    in_ch.light_level    = '0;
    in_ch.distance_level = '0;
    out_ch.ready         = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = CFG_TOO_FAR;
    cfg_data             = '0;
    rst_n                = 1'b0;
    regs        = mk_cfg(6, 100, 30, 50, 1);
    light_avg   = '0;
    dist_avg    = '0;
    light_quiet = '0;
    dist_quiet  = '0;
    waiting     = 1'b0;
    led_off     = 1'b0;
    n_queued    = 0;
    n_accepted  = 0;
    errors      = 0;
    cur_l       = 6'd16;
    cur_d       = 6'd20;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: threshold edges, extreme levels, levels above range
    @(posedge clk);
    push_pass(6'd0, 6'd0);
    push_pass(MaxLevel, MaxLevel);
    push_pass(MaxLevel, 6'd7);
    push_pass(6'd0, 6'd6);
    push_pass(6'd63, 6'd40);
    push_pass(6'd1, 6'd33);
    push_pass(MaxLevel, 6'd63);
    settle();

    // distance limit of one, light off: every far pass ends in wait mode
    apply_cfg(mk_cfg(6, 100, 1, 0, 0));
    @(posedge clk);
    push_pass(6'd5, 6'd20);
    push_pass(6'd5, 6'd20);
    push_pass(6'd5, 6'd31);
    push_pass(6'd5, 6'd6);
    push_pass(6'd5, 6'd0);
    push_pass(6'd5, 6'd10);
    push_pass(6'd5, 6'd2);
    settle();

    // zero light limit: always sleep with LED kept
    apply_cfg(mk_cfg(0, 0, 0, 1023, 1));
    @(posedge clk);
    push_pass(6'd10, 6'd10);
    push_pass(MaxLevel, 6'd0);
    settle();

    // zero distance limit, light off; wait exit at distance 0 gives the longest delay
    apply_cfg(mk_cfg(0, 0, 0, 1023, 0));
    @(posedge clk);
    push_pass(6'd0, 6'd1);
    push_pass(6'd0, 6'd0);
    push_pass(6'd0, 6'd1);
    settle();

    run_phase(mk_cfg(6, 100, 30, 50, 1), 70, 1'b0, 1'b1);
    run_phase(mk_cfg(0, 8, 5, 0, 1), 60, 1'b1, 1'b0);
    run_phase(mk_cfg(10, 127, 127, 1023, 0), 70, 1'b0, 1'b0);
    // limits now sit below the counts built up above
    run_phase(mk_cfg(10, 3, 2, 512, 1), 50, 1'b0, 1'b0);
    run_phase(mk_cfg(32, 127, 127, 1023, 1), 30, 1'b1, 1'b0);
    run_phase(mk_cfg(12, 1, 1, 1, 0), 40, 1'b0, 1'b0);
    repeat (2) begin
      run_phase(mk_cfg($urandom_range(0, 32), $urandom_range(1, 20),
                       $urandom_range(1, 20), $urandom_range(0, 1023),
                       $urandom_range(0, 1)), 40, 1'b0, 1'b0);
    end

    settle();
    repeat (8) @(negedge clk);
    if (due_results.size() != 0) begin
      $error("%0d results never arrived", due_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("parking_aid_blink_controller regression: pass");
    end else begin
      $display("parking_aid_blink_controller regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("parking_aid_blink_controller regression: fail");
    $finish;
  end

endmodule

// ----- parking_aid_blink_controller.f -----
sv/pabc_pkg.sv
sv/pabc_if.sv
sv/pabc_front.sv
sv/pabc_queue.sv
sv/pabc_back.sv
sv/parking_aid_blink_controller.sv
tb/tb_parking_aid_blink_controller.sv
